// File: rtl/core/e2d_pkg.sv
// Shared types, constants and calendar helper functions for the epoch-seconds-to-date core.
// No dependencies; every other file of the block imports this package.
package e2d_pkg;

	localparam int TS_W    = 32;
	localparam int DAYS_W  = 16;
	localparam int YEAR_W  = 12;
	localparam int YLEN_W  = 9;
	localparam int MLEN_W  = 5;
	localparam int CNT_W   = 1;
	localparam int REM_W   = 6;

	localparam logic [YEAR_W-1:0] EPOCH_YEAR     = 12'd1970;
	localparam logic [YEAR_W-1:0] BASE_YEAR      = 12'd2000;
	localparam logic [YEAR_W-1:0] LAST_YEAR      = 12'd2099;
	// The only century in reach of a 32-bit timestamp that is not a leap year.
	localparam logic [YEAR_W-1:0] NOLEAP_CENTURY = 12'd2100;

	localparam logic [3:0] MONTH_FEB  = 4'd1;
	localparam logic [3:0] MONTH_LAST = 4'd11;

	// Offset that makes day zero (a Thursday) come out as weekday 4.
	localparam logic [DAYS_W:0] WDAY_OFFSET = 17'd3;

	// Rounded-up reciprocals. x / 15 is (x * RECIP_15) >> 35 and x / 3 is
	// (x * RECIP_3) >> 33 for any 32-bit x; x / 7 is (x * RECIP_7) >> 32 for x below 2^30.
	localparam logic [TS_W-1:0] RECIP_15 = 32'h88888889;
	localparam logic [TS_W-1:0] RECIP_3  = 32'hAAAAAAAB;
	localparam logic [TS_W-1:0] RECIP_7  = 32'h24924925;

	// Each division pass takes two steps: the reciprocal product, then the remainder.
	localparam logic [CNT_W-1:0] DIV_CNT_INIT = 1'b1;

	typedef logic [1:0] phase_t;
	localparam phase_t PH_SEC  = 2'd0;
	localparam phase_t PH_MIN  = 2'd1;
	localparam phase_t PH_HOUR = 2'd2;
	localparam phase_t PH_WDAY = 2'd3;

	typedef struct packed {
		logic   load;
		logic   div_step;
		logic   div_end;
		phase_t phase;
		logic   year_step;
		logic   month_step;
		logic   capture;
	} cmd_t;

	typedef struct packed {
		logic year_done;
		logic month_done;
	} status_t;

	function automatic logic [REM_W-1:0] div_den(input phase_t ph);
		logic [REM_W-1:0] d;
		unique case (ph)
			PH_SEC:  d = 6'd60;
			PH_MIN:  d = 6'd60;
			PH_HOUR: d = 6'd24;
			PH_WDAY: d = 6'd7;
			default: d = 6'd60;
		endcase
		return d;
	endfunction

	// Gregorian rule, exact for every year a 32-bit timestamp reaches (1970..2106).
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		return (y[1:0] == 2'b00) && (y != NOLEAP_CENTURY);
	endfunction

	function automatic logic [YLEN_W-1:0] year_len(input logic leap);
		return leap ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [MLEN_W-1:0] month_len(input logic [3:0] m, input logic leap);
		logic [MLEN_W-1:0] l;
		unique case (m)
			4'd0:      l = 5'd31;
			MONTH_FEB: l = leap ? 5'd29 : 5'd28;
			4'd2:      l = 5'd31;
			4'd3:      l = 5'd30;
			4'd4:      l = 5'd31;
			4'd5:      l = 5'd30;
			4'd6:      l = 5'd31;
			4'd7:      l = 5'd31;
			4'd8:      l = 5'd30;
			4'd9:      l = 5'd31;
			4'd10:     l = 5'd30;
			4'd11:     l = 5'd31;
			default:   l = 5'd31;
		endcase
		return l;
	endfunction

endpackage

// File: rtl/core/epoch_seconds_to_date_core.sv
// Top level of the epoch-seconds-to-date core: joins the controller and the datapath.
// Depends on e2d_pkg, e2d_ctrl and e2d_dp.
//
// The block turns a 32-bit count of seconds since 1970-01-01 00:00:00 into time of
// day, weekday (Monday is 1), day, month and year minus 2000. Years outside
// 2000..2099 raise out_of_range and report year_out as zero; the other fields stay valid.
// Both channels use valid/ready; a transfer happens on a rising edge with both high.
// The input is taken only while the core is idle, so one item is in work at a time.
// Each item runs through four division passes (by 60, 60, 24 and 7 for the weekday),
// each a reciprocal product followed by a remainder step, then the year walk, the
// month walk and the result capture. The year walk takes the longest, as it steps
// once per year since 1970. A new input transfer can follow only after the previous
// item has been captured, so a new item is not taken before the last one is through.
// The result sits in an output register, so the core goes idle and takes the next
// input while a result still waits; if the receiver stalls, the next result waits
// in the core until the register is free, and the input stays closed meanwhile.
// Reset (arst_n low) empties the output register and returns the controller to idle.
module epoch_seconds_to_date_core import e2d_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [TS_W-1:0] timestamp,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [5:0]      second_out,
	output logic [5:0]      minute_out,
	output logic [4:0]      hour_out,
	output logic [2:0]      weekday_out,
	output logic [4:0]      day_out,
	output logic [3:0]      month_out,
	output logic [6:0]      year_out,
	output logic            out_of_range
);

	cmd_t    cmd;
	status_t status;

	// The controller owns all handshakes and sequencing.
	e2d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// The datapath holds the divider, the calendar walk and the result register.
	e2d_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.timestamp    (timestamp),
		.second_out   (second_out),
		.minute_out   (minute_out),
		.hour_out     (hour_out),
		.weekday_out  (weekday_out),
		.day_out      (day_out),
		.month_out    (month_out),
		.year_out     (year_out),
		.out_of_range (out_of_range)
	);

endmodule

// File: rtl/core/e2d_ctrl.sv
// Sequencing state machine of the epoch-seconds-to-date core.
// Depends on e2d_pkg; drives e2d_dp through cmd_t and reads status_t back.
module e2d_ctrl import e2d_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output cmd_t    cmd,
	input  status_t status
);

	typedef enum logic [2:0] {S_IDLE, S_DIV, S_YEAR, S_MONTH, S_DONE} state_t;

	state_t             state_q;
	phase_t             phase_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		cmd.phase = phase_q;
		unique case (state_q)
			S_IDLE:  cmd.load = in_valid;
			S_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_end  = (cnt_q == '0);
			end
			S_YEAR:  cmd.year_step = 1'b1;
			S_MONTH: cmd.month_step = 1'b1;
			S_DONE:  cmd.capture = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_SEC;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DIV;
						phase_q <= PH_SEC;
						cnt_q   <= DIV_CNT_INIT;
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						if (phase_q == PH_WDAY) begin
							state_q <= S_YEAR;
						end else begin
							phase_q <= phase_q + 2'd1;
							cnt_q   <= DIV_CNT_INIT;
						end
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_YEAR: begin
					if (status.year_done)
						state_q <= S_MONTH;
				end
				S_MONTH: begin
					if (status.month_done)
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (cmd.capture)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A held result must never be overwritten by the next capture.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.capture)
		else $error("result captured while previous result still pending");

	// An accepted item always starts with the seconds division pass.
	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DIV && phase_q == PH_SEC))
		else $error("accepted item did not start the divider");

	// The year walk only starts once the weekday pass has finished.
	a_wday_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_YEAR) |-> (phase_q == PH_WDAY))
		else $error("year walk started before the weekday pass");

endmodule

// File: rtl/core/e2d_dp.sv
// Datapath of the epoch-seconds-to-date core: shared reciprocal-multiply divider,
// year and month step-down registers and the result register. Depends on e2d_pkg.
module e2d_dp import e2d_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output status_t           status,
	input  logic [TS_W-1:0]   timestamp,
	output logic [5:0]        second_out,
	output logic [5:0]        minute_out,
	output logic [4:0]        hour_out,
	output logic [2:0]        weekday_out,
	output logic [4:0]        day_out,
	output logic [3:0]        month_out,
	output logic [6:0]        year_out,
	output logic              out_of_range
);

	logic [TS_W-1:0]    num_q;
	logic [TS_W-1:0]    quot_q;
	logic [REM_W-1:0]   sec_q;
	logic [REM_W-1:0]   min_q;
	logic [4:0]         hour_q;
	logic [2:0]         wday_q;
	logic [DAYS_W-1:0]  days_q;
	logic [YEAR_W-1:0]  year_q;
	logic [3:0]         month_q;

	logic [TS_W-1:0]    mul_a;
	logic [TS_W-1:0]    mul_b;
	logic [2*TS_W-1:0]  prod;
	logic [TS_W-1:0]    quot_next;
	logic [TS_W-1:0]    quot_den;
	logic [TS_W-1:0]    rem_full;
	logic [REM_W-1:0]   rem_next;
	logic [DAYS_W:0]    days_plus;
	logic               leap;
	logic [YLEN_W-1:0]  ylen;
	logic [MLEN_W-1:0]  mlen;
	logic               oor;

	// Division by 60 is a shift by two and a division by 15; by 24 a shift by three
	// and a division by 3. The divisions themselves are reciprocal products.
	always_comb begin
		unique case (cmd.phase)
			PH_SEC, PH_MIN: begin
				mul_a = {2'b00, num_q[TS_W-1:2]};
				mul_b = RECIP_15;
			end
			PH_HOUR: begin
				mul_a = {3'b000, num_q[TS_W-1:3]};
				mul_b = RECIP_3;
			end
			PH_WDAY: begin
				mul_a = num_q;
				mul_b = RECIP_7;
			end
			default: begin
				mul_a = {2'b00, num_q[TS_W-1:2]};
				mul_b = RECIP_15;
			end
		endcase
	end

	assign prod = 64'(mul_a) * 64'(mul_b);

	always_comb begin
		unique case (cmd.phase)
			PH_SEC, PH_MIN: quot_next = {3'b000, prod[2*TS_W-1:TS_W+3]};
			PH_HOUR:        quot_next = {1'b0, prod[2*TS_W-1:TS_W+1]};
			PH_WDAY:        quot_next = prod[2*TS_W-1:TS_W];
			default:        quot_next = {3'b000, prod[2*TS_W-1:TS_W+3]};
		endcase
	end

	// Second step of a pass: the remainder from the registered quotient.
	assign quot_den  = quot_q * TS_W'(div_den(cmd.phase));
	assign rem_full  = num_q - quot_den;
	assign rem_next  = rem_full[REM_W-1:0];
	assign days_plus = {1'b0, quot_q[DAYS_W-1:0]} + WDAY_OFFSET;

	assign leap = is_leap(year_q);
	assign ylen = year_len(leap);
	assign mlen = month_len(month_q, leap);

	assign status.year_done  = (days_q < DAYS_W'(ylen));
	assign status.month_done = (days_q < DAYS_W'(mlen)) || (month_q == MONTH_LAST);

	assign oor = (year_q < BASE_YEAR) || (year_q > LAST_YEAR);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q   <= timestamp;
			year_q  <= EPOCH_YEAR;
			month_q <= '0;
		end else if (cmd.div_step) begin
			if (cmd.div_end) begin
				unique case (cmd.phase)
					PH_SEC: begin
						sec_q <= rem_next;
						num_q <= quot_q;
					end
					PH_MIN: begin
						min_q <= rem_next;
						num_q <= quot_q;
					end
					PH_HOUR: begin
						hour_q <= rem_next[4:0];
						days_q <= quot_q[DAYS_W-1:0];
						num_q  <= {{(TS_W-DAYS_W-1){1'b0}}, days_plus};
					end
					PH_WDAY: begin
						wday_q <= rem_next[2:0] + 3'd1;
					end
					default: ;
				endcase
			end else begin
				quot_q <= quot_next;
			end
		end else if (cmd.year_step) begin
			if (!status.year_done) begin
				days_q <= days_q - DAYS_W'(ylen);
				year_q <= year_q + 12'd1;
			end
		end else if (cmd.month_step) begin
			if (!status.month_done) begin
				days_q  <= days_q - DAYS_W'(mlen);
				month_q <= month_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			second_out   <= sec_q;
			minute_out   <= min_q;
			hour_out     <= hour_q;
			weekday_out  <= wday_q;
			day_out      <= days_q[4:0] + 5'd1;
			month_out    <= month_q + 4'd1;
			year_out     <= oor ? 7'd0 : 7'(year_q - BASE_YEAR);
			out_of_range <= oor;
		end
	end

	// The remainder of every pass lies below the divisor in use.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && cmd.div_end) |-> (rem_full < TS_W'(div_den(cmd.phase))))
		else $error("divider remainder not below divisor");

	// The month walk never steps past December.
	a_month_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.month_step |-> (month_q <= MONTH_LAST))
		else $error("month index past December");

	// The captured day always lies inside its month.
	a_day_in_month: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> (days_q < DAYS_W'(mlen)))
		else $error("day count beyond the length of the month");

endmodule

// File: tb/sv/epoch_seconds_to_date_core_test.sv
// Self-checking testbench for epoch_seconds_to_date_core: directed calendar corners, then
// random timestamps, each checked against a fixed date or a calendar predictor here.
// Depends on e2d_pkg (timestamp width) and the RTL of the core.
module epoch_seconds_to_date_core_test import e2d_pkg::*; ();

	// Clock period is 12 units, so the clock toggles every 6.
	localparam int HALF_PERIOD   = 6;
	// Quiet time after the run, longer than the longest correct computation.
	localparam int DRAIN_CYCLES  = 400;
	// Cycles without any transfer before the run is declared hung.
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_ITEMS  = 400;
	// The receiver refuses results for this long, once, to back the core up.
	localparam int HOLD_CYCLES   = 700;
	localparam int HOLD_AFTER    = 30;
	// Both sides stop idling for this window of random items.
	localparam int STEADY_FIRST  = 150;
	localparam int STEADY_LAST   = 230;
	localparam int IDLE_PERCENT  = 20;

	localparam int unsigned FIRST_YEAR     = 1970;
	localparam int unsigned CENTURY_START  = 2000;
	localparam int unsigned CENTURY_END    = 2099;
	localparam int unsigned DAY_SECONDS    = 86400;
	localparam int unsigned TS_2000        = 32'd946684800;
	localparam int unsigned TS_2100        = 32'd4102444800;
	localparam int unsigned LAST_WHOLE_DAY = 49710;

	localparam logic [2:0] MONDAY    = 3'd1;
	localparam logic [2:0] TUESDAY   = 3'd2;
	localparam logic [2:0] WEDNESDAY = 3'd3;
	localparam logic [2:0] THURSDAY  = 3'd4;
	localparam logic [2:0] FRIDAY    = 3'd5;
	localparam logic [2:0] SATURDAY  = 3'd6;
	localparam logic [2:0] SUNDAY    = 3'd7;

	// One converted date, laid out at the widths of the output ports.
	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [2:0] weekday;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
		logic       oor;
	} cal_t;

	// A row of the directed table. Rows with a fixed date carry it; the rest use the predictor.
	typedef struct {
		logic [TS_W-1:0] ts;
		bit              fixed;
		cal_t            cal;
	} probe_t;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [TS_W-1:0] timestamp;
	logic            out_valid;
	logic            out_ready;
	logic [5:0]      second_out;
	logic [5:0]      minute_out;
	logic [4:0]      hour_out;
	logic [2:0]      weekday_out;
	logic [4:0]      day_out;
	logic [3:0]      month_out;
	logic [6:0]      year_out;
	logic            out_of_range;

	// Dates still owed by the core, oldest first.
	cal_t pending_dates[$];
	// The date that belongs to the timestamp on offer. It changes with a nonblocking
	// assignment, so at the edge of a transfer the monitor still reads the old one.
	cal_t offered_date;
	int   mismatches;
	int   results_seen;
	bit   steady;

	epoch_seconds_to_date_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.timestamp    (timestamp),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.second_out   (second_out),
		.minute_out   (minute_out),
		.hour_out     (hour_out),
		.weekday_out  (weekday_out),
		.day_out      (day_out),
		.month_out    (month_out),
		.year_out     (year_out),
		.out_of_range (out_of_range)
	);

	always #HALF_PERIOD clk = ~clk;

	// Full Gregorian rule, so the predictor does not lean on the 1970..2106 shortcut.
	function automatic bit gregorian_leap(input int unsigned y);
		if (y % 4 != 0)
			return 1'b0;
		if (y % 100 != 0)
			return 1'b1;
		return (y % 400) == 0;
	endfunction

	function automatic cal_t make_date(input int s, input int mi, input int h,
			input logic [2:0] wd, input int d, input int mo, input int y, input bit o);
		cal_t c;
		c.second  = 6'(s);
		c.minute  = 6'(mi);
		c.hour    = 5'(h);
		c.weekday = wd;
		c.day     = 5'(d);
		c.month   = 4'(mo);
		c.year    = 7'(y);
		c.oor     = o;
		return c;
	endfunction

	// Splits a timestamp into time of day and weekday, then walks whole years and whole months off
	// the day count, exactly as a calendar does.
	function automatic cal_t predict_calendar(input logic [TS_W-1:0] ts);
		int unsigned month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		int unsigned t;
		int unsigned days;
		int unsigned yr;
		int unsigned ylen;
		int unsigned mon;
		int unsigned mlen;
		cal_t        c;
		t         = ts;
		c.second  = 6'(t % 60);
		t         = t / 60;
		c.minute  = 6'(t % 60);
		t         = t / 60;
		c.hour    = 5'(t % 24);
		days      = t / 24;
		// Day zero was a Thursday.
		c.weekday = 3'((days + 3) % 7 + 1);
		yr = FIRST_YEAR;
		ylen = gregorian_leap(yr) ? 366 : 365;
		while (days >= ylen) begin
			days = days - ylen;
			yr++;
			ylen = gregorian_leap(yr) ? 366 : 365;
		end
		mon = 0;
		while (mon < 11) begin
			mlen = month_days[mon];
			if (mon == 1 && gregorian_leap(yr))
				mlen = 29;
			if (days < mlen)
				break;
			days = days - mlen;
			mon++;
		end
		c.day   = 5'(days + 1);
		c.month = 4'(mon + 1);
		c.oor   = (yr < CENTURY_START) || (yr > CENTURY_END);
		c.year  = c.oor ? 7'd0 : 7'(yr - CENTURY_START);
		return c;
	endfunction

	// Most random timestamps land anywhere in the 32-bit range or inside the supported
	// century; the rest sit on midnights and new-year boundaries, where the day count,
	// the year walk and the month walk all turn over.
	function automatic logic [TS_W-1:0] pick_timestamp();
		longint      ts;
		int unsigned days;
		int unsigned last_year;
		int unsigned y;
		case ($urandom_range(9))
			0, 1, 2, 3: ts = $urandom();
			4, 5, 6:    ts = TS_2000 + $urandom_range(TS_2100 - TS_2000 - 1);
			7, 8: begin
				ts = longint'($urandom_range(LAST_WHOLE_DAY)) * DAY_SECONDS;
				if (ts != 0 && $urandom_range(1) == 1)
					ts = ts - 1;
			end
			default: begin
				last_year = $urandom_range(2106, FIRST_YEAR + 1);
				days = 0;
				for (y = FIRST_YEAR; y < last_year; y++)
					days = days + (gregorian_leap(y) ? 366 : 365);
				ts = longint'(days) * DAY_SECONDS - $urandom_range(1);
			end
		endcase
		return ts[TS_W-1:0];
	endfunction

	// Offers one timestamp, after a random number of idle cycles, and returns at the edge
	// at which the transfer happens. Valid is only ever dropped during an idle cycle, so
	// back-to-back items keep it high without a second assignment in the same step.
	task automatic offer_timestamp(input logic [TS_W-1:0] ts, input cal_t date);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		timestamp    <= ts;
		offered_date <= date;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Transfers are sampled at the rising edge, before any register in the core or any
	// driver here has taken its new value, so the order of processes does not matter.
	always @(posedge clk) begin : monitor
		cal_t want;
		if (in_valid && in_ready)
			pending_dates.push_back(offered_date);
		if (out_valid && out_ready) begin
			results_seen++;
			if (pending_dates.size() == 0) begin
				mismatches++;
				$display("%0t: result with no input waiting for one, got %0d-%0d-%0d",
					$time, year_out, month_out, day_out);
			end else begin
				want = pending_dates.pop_front();
				check_field("second_out", want.second, second_out);
				check_field("minute_out", want.minute, minute_out);
				check_field("hour_out", want.hour, hour_out);
				check_field("weekday_out", want.weekday, weekday_out);
				check_field("day_out", want.day, day_out);
				check_field("month_out", want.month, month_out);
				check_field("year_out", want.year, year_out);
				check_field("out_of_range", want.oor, out_of_range);
			end
		end
	end

	// The receiver takes results at random, except in the steady window, and once stops
	// taking them for a long while. The sender keeps offering during that hold-off, so
	// the core finishes the next item behind the full output register and closes its input.
	initial begin : receiver
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end
			out_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// A hung core shows up as a long run of cycles with no transfer on either side.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		probe_t      corners [];
		logic [TS_W-1:0] ts;
		int          n;
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		timestamp    = '0;
		offered_date = '0;
		mismatches   = 0;
		results_seen = 0;
		steady       = 1'b0;

		// Epoch start, both ends of the supported century, the non-leap century 2100,
		// leap days in 1972, 2000 and 2024, and the top of the 32-bit range.
		corners = '{
			'{32'd0,          1'b1, make_date(0, 0, 0, THURSDAY, 1, 1, 0, 1'b1)},
			'{32'd59,         1'b0, '0},
			'{32'd946684799,  1'b1, make_date(59, 59, 23, FRIDAY, 31, 12, 0, 1'b1)},
			'{32'd946684800,  1'b1, make_date(0, 0, 0, SATURDAY, 1, 1, 0, 1'b0)},
			'{32'd951782400,  1'b0, '0},
			'{32'd951868800,  1'b0, '0},
			'{32'd68169600,   1'b0, '0},
			'{32'd1709164800, 1'b0, '0},
			'{32'd1735689599, 1'b0, '0},
			'{32'd4102444799, 1'b1, make_date(59, 59, 23, THURSDAY, 31, 12, 99, 1'b0)},
			'{32'd4102444800, 1'b1, make_date(0, 0, 0, FRIDAY, 1, 1, 0, 1'b1)},
			'{32'd4107455999, 1'b0, '0},
			'{32'd4107542400, 1'b0, '0},
			'{32'hFFFFFFFF,   1'b1, make_date(15, 28, 6, SUNDAY, 7, 2, 0, 1'b1)},
			'{32'h7FFFFFFF,   1'b0, '0},
			'{32'h80000000,   1'b0, '0},
			'{32'hAAAAAAAA,   1'b0, '0},
			'{32'h55555555,   1'b0, '0}
		};

		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;

		foreach (corners[i])
			offer_timestamp(corners[i].ts,
				corners[i].fixed ? corners[i].cal : predict_calendar(corners[i].ts));

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			steady = (n >= STEADY_FIRST) && (n < STEADY_LAST);
			ts = pick_timestamp();
			offer_timestamp(ts, predict_calendar(ts));
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		// Let the monitor log the last transfer, then wait for every owed date and
		// allow a full computation time for anything the core should not produce.
		@(posedge clk);
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
